/* rtl/core/imf_pkg.sv */
`default_nettype none

package imf_pkg;

	localparam int DATA_W = 16;
	localparam int NCH    = 6;

	// channel order inside the datapath
	localparam int CH_ACC_X  = 0;
	localparam int CH_ACC_Y  = 1;
	localparam int CH_ACC_Z  = 2;
	localparam int CH_GYRO_X = 3;
	localparam int CH_GYRO_Y = 4;
	localparam int CH_GYRO_Z = 5;

	// register indexes, byte address = 4 * index
	localparam int          ADDR_W       = 4;
	localparam logic [1:0]  REG_ACC_OFS0 = 2'd0;
	localparam logic [1:0]  REG_ACC_OFS1 = 2'd1;
	localparam logic [1:0]  REG_ACC_OFS2 = 2'd2;
	localparam logic [1:0]  REG_NEG_GY   = 2'd3;

	typedef struct packed {
		logic capture;   // latch a new request's samples
		logic push;      // write samples into the windows
		logic scan_clr;  // reset the candidate index
		logic scan_step; // test one candidate, advance
		logic out_load;  // load the output register
	} imf_cmd_t;

	typedef struct packed {
		logic bad;       // trailer of captured request nonzero
		logic scan_last; // current candidate is the last window entry
	} imf_sts_t;

endpackage

`default_nettype wire

/* rtl/core/imf_ctrl.sv */
`default_nettype none

module imf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output imf_pkg::imf_cmd_t      cmd,
	input  wire imf_pkg::imf_sts_t sts
);
	import imf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_PUSH   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.capture   = in_valid && (state_q == S_IDLE);
		cmd.push      = (state_q == S_PUSH) && !sts.bad;
		cmd.scan_clr  = (state_q == S_PUSH);
		cmd.scan_step = (state_q == S_SCAN);
		cmd.out_load  = (state_q == S_RESULT) && (!out_valid_q || !out_stall);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_PUSH;
			end
			S_PUSH: begin
				state_nxt = sts.bad ? S_RESULT : S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_last) state_nxt = S_RESULT;
			end
			S_RESULT: begin
				if (cmd.out_load) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/imf_datapath.sv */
`default_nettype none

module imf_datapath #(
	parameter int WINDOW_DEPTH = 5
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire imf_pkg::imf_cmd_t           cmd,
	output imf_pkg::imf_sts_t                sts,
	input  wire logic [31:0]                 gyro_x_raw,
	input  wire logic [31:0]                 gyro_y_raw,
	input  wire logic [31:0]                 gyro_z_raw,
	input  wire logic [15:0]                 acc_word0_raw,
	input  wire logic [15:0]                 acc_word1_raw,
	input  wire logic [15:0]                 acc_word2_raw,
	input  wire logic [31:0]                 trailer_raw,
	input  wire logic signed [15:0]          acc_offset_word0,
	input  wire logic signed [15:0]          acc_offset_word1,
	input  wire logic signed [15:0]          acc_offset_word2,
	input  wire logic                        negate_gyro_y,
	output logic                             frame_bad,
	output logic signed [15:0]               median_acc_x,
	output logic signed [15:0]               median_acc_y,
	output logic signed [15:0]               median_acc_z,
	output logic signed [15:0]               median_gyro_x,
	output logic signed [15:0]               median_gyro_y,
	output logic signed [15:0]               median_gyro_z
);
	import imf_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

	logic signed [DATA_W-1:0] samp_nxt [NCH];
	logic signed [DATA_W-1:0] samp_q   [NCH];
	logic                     bad_q;
	logic signed [DATA_W-1:0] win_q    [NCH][WINDOW_DEPTH];
	logic        [CNT_W-1:0]  count_q;
	logic        [IDX_W-1:0]  cand_q;
	logic signed [DATA_W-1:0] cand_val [NCH];
	logic        [CNT_W-1:0]  less_c   [NCH];
	logic        [CNT_W-1:0]  leq_c    [NCH];
	logic        [NCH-1:0]    hit;
	logic        [CNT_W-1:0]  half;
	logic signed [DATA_W-1:0] med_q    [NCH];
	logic signed [DATA_W-1:0] res_q    [NCH];
	logic                     bad_out_q;

	// sample extraction
	function automatic logic signed [DATA_W-1:0] acc_conv(
		input logic [15:0] word,
		input logic signed [15:0] ofs
	);
		logic signed [16:0] d;
		begin
			d = 17'(signed'(word)) - 17'(ofs);
			acc_conv = DATA_W'(d >>> 2);
		end
	endfunction

	always_comb begin
		samp_nxt[CH_GYRO_X] = gyro_x_raw[25:10];
		samp_nxt[CH_GYRO_Y] = negate_gyro_y ? DATA_W'(-signed'(gyro_y_raw[25:10]))
		                                    : signed'(gyro_y_raw[25:10]);
		samp_nxt[CH_GYRO_Z] = gyro_z_raw[25:10];
		samp_nxt[CH_ACC_Y]  = acc_conv(acc_word0_raw, acc_offset_word0);
		samp_nxt[CH_ACC_X]  = acc_conv(acc_word1_raw, acc_offset_word1);
		samp_nxt[CH_ACC_Z]  = acc_conv(acc_word2_raw, acc_offset_word2);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int c = 0; c < NCH; c++) samp_q[c] <= samp_nxt[c];
			bad_q <= (trailer_raw != 32'd0);
		end
	end

	// windows: fill at the count, then shift out the oldest
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int c = 0; c < NCH; c++) begin
				if (count_q < CNT_W'(WINDOW_DEPTH)) begin
					win_q[c][count_q[IDX_W-1:0]] <= samp_q[c];
				end else begin
					for (int k = 1; k < WINDOW_DEPTH; k++) win_q[c][k-1] <= win_q[c][k];
					win_q[c][WINDOW_DEPTH-1] <= samp_q[c];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push && (count_q < CNT_W'(WINDOW_DEPTH))) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// rank test: candidate is the median if less <= n/2 < less_or_equal
	assign half = count_q >> 1;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			cand_val[c] = win_q[c][cand_q];
			less_c[c]   = '0;
			leq_c[c]    = '0;
			for (int j = 0; j < WINDOW_DEPTH; j++) begin
				if (CNT_W'(j) < count_q) begin
					if (win_q[c][j] < cand_val[c])  less_c[c] = less_c[c] + CNT_W'(1);
					if (win_q[c][j] <= cand_val[c]) leq_c[c]  = leq_c[c] + CNT_W'(1);
				end
			end
			hit[c] = (less_c[c] <= half) && (half < leq_c[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (cmd.scan_clr) begin
			cand_q <= '0;
		end else if (cmd.scan_step && !sts.scan_last) begin
			cand_q <= cand_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			for (int c = 0; c < NCH; c++)
				if (hit[c]) med_q[c] <= cand_val[c];
		end
	end

	assign sts.bad       = bad_q;
	assign sts.scan_last = (CNT_W'(cand_q) == (count_q - CNT_W'(1)));

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			bad_out_q <= bad_q;
			for (int c = 0; c < NCH; c++) res_q[c] <= bad_q ? '0 : med_q[c];
		end
	end

	assign frame_bad     = bad_out_q;
	assign median_acc_x  = res_q[CH_ACC_X];
	assign median_acc_y  = res_q[CH_ACC_Y];
	assign median_acc_z  = res_q[CH_ACC_Z];
	assign median_gyro_x = res_q[CH_GYRO_X];
	assign median_gyro_y = res_q[CH_GYRO_Y];
	assign median_gyro_z = res_q[CH_GYRO_Z];

endmodule

`default_nettype wire

/* rtl/core/imu_frame_median_filter_top.sv */
`default_nettype none
// A good request passes from acceptance through push, a rank scan over the n filled
// window entries (n being the window fill after the push, 1..WINDOW_DEPTH) and the
// output register; a bad-trailer request skips the scan. A new request is taken only
// once the last result is loaded; the scan tests one window entry per cycle, all six channels in parallel.
// Reset (arst_n, async, active low): controller idle, output empty, sample count and
// configuration registers cleared; window contents are not reset.

module imu_frame_median_filter_top #(
	parameter int WINDOW_DEPTH = 5
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// APB configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [imf_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	// request channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [31:0]                  gyro_x_raw,
	input  wire logic [31:0]                  gyro_y_raw,
	input  wire logic [31:0]                  gyro_z_raw,
	input  wire logic [15:0]                  acc_word0_raw,
	input  wire logic [15:0]                  acc_word1_raw,
	input  wire logic [15:0]                  acc_word2_raw,
	input  wire logic [31:0]                  trailer_raw,
	// result channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              frame_bad,
	output logic signed [15:0]                median_acc_x,
	output logic signed [15:0]                median_acc_y,
	output logic signed [15:0]                median_acc_z,
	output logic signed [15:0]                median_gyro_x,
	output logic signed [15:0]                median_gyro_y,
	output logic signed [15:0]                median_gyro_z
);
	import imf_pkg::*;

	// Configuration registers. Decode uses the word index only, so any
	// byte offset inside a word hits that word's register.
	logic signed [15:0] acc_ofs0_q;
	logic signed [15:0] acc_ofs1_q;
	logic signed [15:0] acc_ofs2_q;
	logic               neg_gy_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_ofs0_q <= '0;
			acc_ofs1_q <= '0;
			acc_ofs2_q <= '0;
			neg_gy_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ACC_OFS0: acc_ofs0_q <= pwdata[15:0];
				REG_ACC_OFS1: acc_ofs1_q <= pwdata[15:0];
				REG_ACC_OFS2: acc_ofs2_q <= pwdata[15:0];
				REG_NEG_GY:   neg_gy_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// readback, zero-extended
	always_comb begin
		case (paddr[3:2])
			REG_ACC_OFS0: prdata = {16'd0, acc_ofs0_q};
			REG_ACC_OFS1: prdata = {16'd0, acc_ofs1_q};
			REG_ACC_OFS2: prdata = {16'd0, acc_ofs2_q};
			REG_NEG_GY:   prdata = {31'd0, neg_gy_q};
			default:      prdata = '0;
		endcase
	end

	// Controller sequences capture -> push -> scan -> result; the datapath
	// holds the samples, windows, rank compare and the output register.
	imf_cmd_t cmd;
	imf_sts_t sts;

	imf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	imf_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.gyro_x_raw       (gyro_x_raw),
		.gyro_y_raw       (gyro_y_raw),
		.gyro_z_raw       (gyro_z_raw),
		.acc_word0_raw    (acc_word0_raw),
		.acc_word1_raw    (acc_word1_raw),
		.acc_word2_raw    (acc_word2_raw),
		.trailer_raw      (trailer_raw),
		.acc_offset_word0 (acc_ofs0_q),
		.acc_offset_word1 (acc_ofs1_q),
		.acc_offset_word2 (acc_ofs2_q),
		.negate_gyro_y    (neg_gy_q),
		.frame_bad        (frame_bad),
		.median_acc_x     (median_acc_x),
		.median_acc_y     (median_acc_y),
		.median_acc_z     (median_acc_z),
		.median_gyro_x    (median_gyro_x),
		.median_gyro_y    (median_gyro_y),
		.median_gyro_z    (median_gyro_z)
	);

endmodule

`default_nettype wire
